>>> rtl/dsfp_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the dust sensor reply frame parser
// no dependencies; imported by every module of the block
package dsfp_pkg;

    localparam int FRAME_LENGTH = 10;
    localparam int POS_W        = 4;

    localparam logic [POS_W-1:0] POS_HEAD = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ID   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SUM  = POS_W'(FRAME_LENGTH - 2);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(FRAME_LENGTH);

    // action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HEAD = 3'd1;
    localparam logic [2:0] ST_BAD_ID   = 3'd2;
    localparam logic [2:0] ST_BAD_SUM  = 3'd3;
    localparam logic [2:0] ST_BAD_TAIL = 3'd4;
    localparam logic [2:0] ST_TIMEOUT  = 3'd5;

    // register indexes, byte address is 4 * index
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_HEAD    = 3'd0;
    localparam logic [2:0] REG_REPLY   = 3'd1;
    localparam logic [2:0] REG_REPORT  = 3'd2;
    localparam logic [2:0] REG_TAIL    = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [15:0]      pm25_tenths;
        logic [15:0]      pm10_tenths;
        logic [POS_W-1:0] bytes_seen;
    } t_result;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic [7:0]  reply_id;
        logic [7:0]  report_id;
        logic [7:0]  tail_byte;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

>>> rtl/dsfp_cfg_regs.sv
`timescale 1ns / 1ps
// apb register file holding the frame match bytes and the timeout
// depends on dsfp_pkg
module dsfp_cfg_regs import dsfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_byte     <= 8'd170;
            r_cfg.reply_id      <= 8'd197;
            r_cfg.report_id     <= 8'd192;
            r_cfg.tail_byte     <= 8'd171;
            r_cfg.timeout_ticks <= 16'd1000;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_HEAD:    r_cfg.head_byte     <= pwdata[7:0];
                REG_REPLY:   r_cfg.reply_id      <= pwdata[7:0];
                REG_REPORT:  r_cfg.report_id     <= pwdata[7:0];
                REG_TAIL:    r_cfg.tail_byte     <= pwdata[7:0];
                REG_TIMEOUT: r_cfg.timeout_ticks <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_HEAD:    prdata = {24'd0, r_cfg.head_byte};
            REG_REPLY:   prdata = {24'd0, r_cfg.reply_id};
            REG_REPORT:  prdata = {24'd0, r_cfg.report_id};
            REG_TAIL:    prdata = {24'd0, r_cfg.tail_byte};
            REG_TIMEOUT: prdata = {16'd0, r_cfg.timeout_ticks};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/dsfp_frame_core.sv
`timescale 1ns / 1ps
// frame check state and per-item decision logic, one item per enabled cycle
// depends on dsfp_pkg
module dsfp_frame_core import dsfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    logic             r_armed;
    logic [POS_W-1:0] r_index;
    logic [7:0]       r_sum;
    logic [15:0]      r_elapsed;
    logic [7:0]       r_payload [4];

    logic             n_armed;
    logic [POS_W-1:0] n_index;
    logic [7:0]       n_sum;
    logic [15:0]      n_elapsed;
    logic             pl_we;
    logic [1:0]       pl_sel;
    logic [15:0]      el_inc;
    logic             timed_out;
    logic [7:0]       b;

    assign b         = i_item.rx_byte;
    assign el_inc    = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign timed_out = r_elapsed >= i_cfg.timeout_ticks;
    assign pl_sel    = 2'(r_index - POS_DATA);

    always_comb begin
        n_armed     = r_armed;
        n_index     = r_index;
        n_sum       = r_sum;
        n_elapsed   = r_elapsed;
        pl_we       = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_TIMEOUT, pm25_tenths: 16'd0, pm10_tenths: 16'd0,
                        bytes_seen: r_index};
        if (i_item.action == ACT_START) begin
            n_armed   = 1'b1;
            n_index   = '0;
            n_sum     = 8'd0;
            n_elapsed = 16'd0;
        end else if (r_armed) begin
            if (i_item.action == ACT_TICK) begin
                n_elapsed = el_inc;
                if (el_inc >= i_cfg.timeout_ticks) begin
                    n_armed     = 1'b0;
                    o_res_valid = 1'b1;
                end
            end else if (i_item.action == ACT_BYTE) begin
                n_index = r_index + POS_W'(1);
                // position decides which check applies; first failure disarms
                priority if (timed_out) begin
                    n_index     = r_index;
                    n_armed     = 1'b0;
                    o_res_valid = 1'b1;
                end else if (r_index == POS_HEAD) begin
                    if (b != i_cfg.head_byte) begin
                        n_index      = r_index;
                        n_armed      = 1'b0;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_BAD_HEAD;
                    end
                end else if (r_index == POS_ID) begin
                    if (b != i_cfg.reply_id && b != i_cfg.report_id) begin
                        n_index      = r_index;
                        n_armed      = 1'b0;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_BAD_ID;
                    end
                end else if (r_index < POS_SUM) begin
                    pl_we = (r_index < POS_DATA + POS_W'(4));
                    n_sum = r_sum + b;
                end else if (r_index == POS_SUM) begin
                    if (b != r_sum) begin
                        n_index      = r_index;
                        n_armed      = 1'b0;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_BAD_SUM;
                    end
                end else begin
                    n_armed     = 1'b0;
                    o_res_valid = 1'b1;
                    if (b != i_cfg.tail_byte) begin
                        n_index      = r_index;
                        o_res.status = ST_BAD_TAIL;
                    end else begin
                        n_index           = POS_END;
                        o_res.status      = ST_OK;
                        o_res.pm25_tenths = {r_payload[1], r_payload[0]};
                        o_res.pm10_tenths = {r_payload[3], r_payload[2]};
                        o_res.bytes_seen  = POS_END;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_index   <= '0;
            r_sum     <= 8'd0;
            r_elapsed <= 16'd0;
        end else if (i_fire) begin
            r_armed   <= n_armed;
            r_index   <= n_index;
            r_sum     <= n_sum;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && pl_we) begin
            r_payload[pl_sel] <= b;
        end
    end

endmodule

>>> rtl/dust_sensor_response_frame_parser.sv
`timescale 1ns / 1ps
// top level: input register, frame check core, result register, apb registers
// depends on dsfp_pkg, dsfp_cfg_regs, dsfp_frame_core
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_item  (action, rx_byte)
//  result   | o_out_valid  | i_out_stall  | o_out_item (status, pm, bytes_seen)
//  config   | psel/penable | pready = 1   | paddr, pwdata, prdata
//
// one item per cycle sustained unless i_out_stall; each result passes the
// input register, then the result register. the core updates its state in the
// cycle it processes an item, so back-to-back beats need no bubbles.
// reset is synchronous; nothing needs clearing after it.
// a stalled result holds the core; o_in_stall rises only when the input
// register is full and cannot move.
module dust_sensor_response_frame_parser import dsfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_item             i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_result           o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_item;

    logic    adv;
    logic    fire;
    logic    res_valid;
    t_result res;
    t_cfg    cfg;

    assign adv         = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && adv;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    dsfp_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dsfp_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= fire && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (fire && res_valid) begin
            r_out_item <= res;
        end
    end

    a_ok_full_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_OK) |-> (o_out_item.bytes_seen == POS_END))
        else $error("ok result without a full frame count");

    a_err_no_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_OK)
            |-> (o_out_item.pm25_tenths == 16'd0 && o_out_item.pm10_tenths == 16'd0))
        else $error("error result carries measurement values");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a blocked result");

    a_no_fire_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_item)))
        else $error("held result was overwritten");

endmodule

>>> dv/tb_dust_sensor_response_frame_parser.sv
`timescale 1ns / 1ps
// self-checking testbench for the dust sensor reply frame parser: directed beats, then
// random frames under several register settings, checked against a cycle-free predictor
// depends on dsfp_pkg and dust_sensor_response_frame_parser
module tb_dust_sensor_response_frame_parser;
    import dsfp_pkg::*;

    localparam logic [1:0]       ACT_UNUSED = 2'd3;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_item             in_item = '0;
    logic              out_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_result           o_out_item;
    logic [31:0]       prdata;
    logic              pready;

    // parser state as the frame checker sees it
    t_cfg             cfg;
    logic             armed_q;
    logic [POS_W-1:0] pos_q;
    logic [7:0]       sum_q;
    logic [7:0]       pm_bytes [4];
    logic [15:0]      ticks_q;

    t_result want_q [$];
    t_row    steps [$];
    int      fails = 0;
    bit      jitter_on = 1'b1;

    dust_sensor_response_frame_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_dust_sensor_response_frame_parser failed");
        $finish;
    end

    // returns 1 when the beat produces a result
    function automatic bit parse_step(input t_item it, output t_result res);
        bit         done;
        logic [2:0] st;
        done = 1'b0;
        st   = ST_OK;
        res  = '0;
        if (it.action == ACT_START) begin
            armed_q = 1'b1;
            pos_q   = POS_HEAD;
            sum_q   = '0;
            ticks_q = '0;
        end else if (armed_q && it.action == ACT_TICK) begin
            if (ticks_q != 16'hFFFF)
                ticks_q = ticks_q + 16'd1;
            if (ticks_q >= cfg.timeout_ticks) begin
                done = 1'b1;
                st   = ST_TIMEOUT;
            end
        end else if (armed_q && it.action == ACT_BYTE) begin
            if (ticks_q >= cfg.timeout_ticks) begin
                done = 1'b1;
                st   = ST_TIMEOUT;
            end else if (pos_q == POS_HEAD) begin
                done = it.rx_byte != cfg.head_byte;
                st   = ST_BAD_HEAD;
            end else if (pos_q == POS_ID) begin
                done = it.rx_byte != cfg.reply_id && it.rx_byte != cfg.report_id;
                st   = ST_BAD_ID;
            end else if (pos_q < POS_SUM) begin
                if (pos_q - POS_DATA < 4)
                    pm_bytes[2'(pos_q - POS_DATA)] = it.rx_byte;
                sum_q = sum_q + it.rx_byte;
            end else if (pos_q == POS_SUM) begin
                done = it.rx_byte != sum_q;
                st   = ST_BAD_SUM;
            end else begin
                done = 1'b1;
                st   = (it.rx_byte == cfg.tail_byte) ? ST_OK : ST_BAD_TAIL;
            end
            if (!done)
                pos_q = pos_q + 1'b1;
        end
        if (done) begin
            armed_q = 1'b0;
            if (st == ST_OK) begin
                pos_q           = POS_END;
                res.pm25_tenths = {pm_bytes[1], pm_bytes[0]};
                res.pm10_tenths = {pm_bytes[3], pm_bytes[2]};
            end
            res.status     = st;
            res.bytes_seen = pos_q;
        end
        return done;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_row(input t_item it, input bit typed = 1'b0,
                                    input t_result want = '0);
        steps.push_back('{it, typed, want});
    endfunction

    // entered and left at a falling edge
    task automatic drive_beat(input t_item it, input bit typed = 1'b0,
                              input t_result want = '0);
        t_result pred;
        bit      hit;
        while (jitter_on && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        hit = parse_step(it, pred);
        if (typed)
            want_q.push_back(want);
        else if (hit)
            want_q.push_back(pred);
        @(negedge i_clk);
    endtask

    // drop valid and wait for every result, then for the pipeline to drain
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (want_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_HEAD:    cfg.head_byte     = val[7:0];
            REG_REPLY:   cfg.reply_id      = val[7:0];
            REG_REPORT:  cfg.report_id     = val[7:0];
            REG_TAIL:    cfg.tail_byte     = val[7:0];
            REG_TIMEOUT: cfg.timeout_ticks = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        drain();
        set_reg(REG_HEAD, 16'(c.head_byte));
        set_reg(REG_REPLY, 16'(c.reply_id));
        set_reg(REG_REPORT, 16'(c.report_id));
        set_reg(REG_TAIL, 16'(c.tail_byte));
        set_reg(REG_TIMEOUT, c.timeout_ticks);
    endtask

    // mostly clean frames with random payload, some corrupted or cut short
    task automatic send_frame();
        logic [7:0] fb [FRAME_LENGTH];
        logic [7:0] csum;
        int         r;
        int         cut;
        r    = $urandom_range(99);
        cut  = FRAME_LENGTH;
        csum = '0;
        fb[0] = cfg.head_byte;
        fb[1] = $urandom_range(1) ? cfg.reply_id : cfg.report_id;
        for (int k = 2; k < FRAME_LENGTH - 2; k++) begin
            fb[k] = pick_byte();
            csum  = csum + fb[k];
        end
        fb[FRAME_LENGTH-2] = csum;
        fb[FRAME_LENGTH-1] = cfg.tail_byte;
        if (r < 8) begin
            fb[0] ^= 8'($urandom_range(1, 255));
        end else if (r < 14) begin
            do
                fb[1] = 8'($urandom_range(255));
            while (fb[1] == cfg.reply_id || fb[1] == cfg.report_id);
        end else if (r < 22) begin
            fb[FRAME_LENGTH-2] ^= 8'($urandom_range(1, 255));
        end else if (r < 30) begin
            fb[FRAME_LENGTH-1] ^= 8'($urandom_range(1, 255));
        end else if (r < 36) begin
            cut = $urandom_range(0, FRAME_LENGTH - 1);
        end
        drive_beat({ACT_START, 8'($urandom)});
        for (int k = 0; k < cut; k++) begin
            if ($urandom_range(99) < 15)
                drive_beat({ACT_TICK, 8'($urandom)});
            if ($urandom_range(99) < 3)
                drive_beat({ACT_UNUSED, 8'($urandom)});
            drive_beat({ACT_BYTE, fb[k]});
        end
        // stray byte after the frame, normally dropped
        if ($urandom_range(99) < 10)
            drive_beat({ACT_BYTE, pick_byte()});
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (rst_n && o_out_valid && !out_stall) begin
            if (want_q.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_item);
                fails++;
            end else begin
                w = want_q.pop_front();
                check_field("status", w.status, o_out_item.status);
                check_field("pm25_tenths", w.pm25_tenths, o_out_item.pm25_tenths);
                check_field("pm10_tenths", w.pm10_tenths, o_out_item.pm10_tenths);
                check_field("bytes_seen", w.bytes_seen, o_out_item.bytes_seen);
            end
        end
    end

    always @(negedge i_clk)
        out_stall <= jitter_on && ($urandom_range(99) < 33);

    initial begin
        t_cfg c;
        cfg      = '{8'd170, 8'd197, 8'd192, 8'd171, 16'd1000};
        armed_q  = 1'b0;
        pos_q    = POS_HEAD;
        sum_q    = '0;
        ticks_q  = '0;
        pm_bytes = '{default: 8'h00};

        // reset register values: head AA, ids C5 / C0, tail AB, timeout 1000
        add_row({ACT_BYTE, 8'h55});
        add_row({ACT_TICK, 8'h00});
        add_row({ACT_START, 8'hFF});
        add_row({ACT_BYTE, 8'h00}, 1'b1, '{ST_BAD_HEAD, 16'h0, 16'h0, 4'd0});
        add_row({ACT_START, 8'h00});
        add_row({ACT_BYTE, 8'hAA});
        add_row({ACT_BYTE, 8'hFF}, 1'b1, '{ST_BAD_ID, 16'h0, 16'h0, 4'd1});
        add_row({ACT_START, 8'h00});
        add_row({ACT_BYTE, 8'hAA});
        add_row({ACT_BYTE, 8'hC5});
        add_row({ACT_START, 8'h00});
        add_row({ACT_BYTE, 8'hAA});
        add_row({ACT_BYTE, 8'hC0});
        repeat (6) add_row({ACT_BYTE, 8'hFF});
        add_row({ACT_UNUSED, 8'hFF});
        add_row({ACT_TICK, 8'h00});
        add_row({ACT_BYTE, 8'hFA});
        add_row({ACT_BYTE, 8'hAB}, 1'b1, '{ST_OK, 16'hFFFF, 16'hFFFF, 4'd10});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (steps[i])
            drive_beat(steps[i].item, steps[i].typed, steps[i].want);

        // timeout lowered under a frame in progress, then a tick-driven timeout
        drain();
        set_reg(REG_TIMEOUT, 16'd5);
        drive_beat({ACT_START, 8'h00});
        drive_beat({ACT_BYTE, 8'hAA});
        drive_beat({ACT_BYTE, 8'hC5});
        repeat (3) drive_beat({ACT_TICK, 8'h00});
        drain();
        set_reg(REG_TIMEOUT, 16'd2);
        drive_beat({ACT_BYTE, 8'h3C}, 1'b1, '{ST_TIMEOUT, 16'h0, 16'h0, 4'd2});
        drive_beat({ACT_START, 8'h00});
        drive_beat({ACT_TICK, 8'h00});
        drive_beat({ACT_TICK, 8'h00}, 1'b1, '{ST_TIMEOUT, 16'h0, 16'h0, 4'd0});
        drain();
        set_reg(REG_TIMEOUT, 16'd1000);

        for (int p = 0; p < 10; p++) begin
            c = cfg;
            if (p == 1) begin
                c = '{8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF};
            end else if (p == 2) begin
                c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000};
            end else if (p > 2) begin
                c.head_byte     = 8'($urandom);
                c.reply_id      = 8'($urandom);
                c.report_id     = $urandom_range(3) == 0 ? c.reply_id : 8'($urandom);
                c.tail_byte     = 8'($urandom);
                c.timeout_ticks = $urandom_range(1) ? 16'($urandom_range(1, 6))
                                                    : 16'($urandom_range(7, 65535));
            end
            // long stretch with no gaps on either side
            jitter_on = !(p == 5 || p == 6);
            if (p != 0)
                load_cfg(c);
            repeat (p == 2 ? 6 : 12) send_frame();
        end

        drain();
        if (fails == 0)
            $display("tb_dust_sensor_response_frame_parser passed");
        else
            $display("tb_dust_sensor_response_frame_parser failed");
        $finish;
    end

endmodule
